// File: hdl/rwts_pkg.sv
// Package for the romaji word token scanner: token codes, DFA state codes,
// the reserved-word table and the per-character helper functions.
// No dependencies.
package rwts_pkg;

  // Stream, position and DFA state widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned SYL_W    = 4;
  localparam int unsigned PER_W    = 2;

  // Reserved-word table size; one extra match flag covers the end marker
  localparam int unsigned NUM_RESERVED = 18;
  localparam int unsigned MATCH_W      = NUM_RESERVED + 1;
  localparam int unsigned RW_MAX_LEN   = 12;
  localparam int unsigned RW_TEXT_W    = RW_MAX_LEN * CHAR_W;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] EOFM_LEN = 4'd4;

  // Token codes
  typedef enum logic [3:0] {
    TOK_ERROR,
    TOK_EOFM,
    TOK_PERIOD,
    TOK_WORD1,
    TOK_WORD2,
    TOK_VERB,
    TOK_VERBNEG,
    TOK_VERBPAST,
    TOK_VERBPASTNEG,
    TOK_IS,
    TOK_WAS,
    TOK_OBJECT,
    TOK_SUBJECT,
    TOK_DEST,
    TOK_PRONOUN,
    TOK_CONNECTOR
  } tok_e;

  // Syllable DFA state codes
  localparam logic [SYL_W-1:0] SYL_START = 4'd0;
  localparam logic [SYL_W-1:0] SYL_T     = 4'd1;
  localparam logic [SYL_W-1:0] SYL_S     = 4'd2;
  localparam logic [SYL_W-1:0] SYL_C     = 4'd3;
  localparam logic [SYL_W-1:0] SYL_VOWEL = 4'd4;
  localparam logic [SYL_W-1:0] SYL_GLIDE = 4'd5;
  localparam logic [SYL_W-1:0] SYL_ONSET = 4'd6;
  localparam logic [SYL_W-1:0] SYL_N     = 4'd7;
  localparam logic [SYL_W-1:0] SYL_DEAD  = 4'd8;

  // Period DFA state codes
  localparam logic [PER_W-1:0] PER_START = 2'd0;
  localparam logic [PER_W-1:0] PER_ONE   = 2'd1;
  localparam logic [PER_W-1:0] PER_DEAD  = 2'd2;

  // Reserved words, right-aligned: the last character sits in the low byte
  localparam logic [RW_TEXT_W-1:0] RW_TEXT [NUM_RESERVED] = '{
    RW_TEXT_W'("masu"),    RW_TEXT_W'("masen"),    RW_TEXT_W'("mashita"),
    RW_TEXT_W'("masendeshita"), RW_TEXT_W'("desu"), RW_TEXT_W'("deshita"),
    RW_TEXT_W'("o"),       RW_TEXT_W'("wa"),       RW_TEXT_W'("ni"),
    RW_TEXT_W'("watashi"), RW_TEXT_W'("anata"),    RW_TEXT_W'("kare"),
    RW_TEXT_W'("kanoja"),  RW_TEXT_W'("sore"),     RW_TEXT_W'("mata"),
    RW_TEXT_W'("soshite"), RW_TEXT_W'("shikashi"), RW_TEXT_W'("dakara")
  };

  localparam logic [POS_W-1:0] RW_LEN [NUM_RESERVED] = '{
    4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2,
    4'd7, 4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6
  };

  localparam tok_e RW_CLASS [NUM_RESERVED] = '{
    TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
    TOK_OBJECT, TOK_SUBJECT, TOK_DEST, TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN,
    TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR, TOK_CONNECTOR,
    TOK_CONNECTOR
  };

  localparam logic [4*CHAR_W-1:0] EOFM_TEXT = "eofm";

  // Character at position p of reserved word i; zero past its end
  function automatic logic [CHAR_W-1:0] rw_char(int unsigned i, logic [POS_W-1:0] p);
    logic [POS_W-1:0] b;
    b = RW_LEN[i] - p - 4'd1;
    if (p >= RW_LEN[i]) begin
      return '0;
    end
    return RW_TEXT[i][{b, 3'b000} +: CHAR_W];
  endfunction

  // Character at position p of the end marker; zero past its end
  function automatic logic [CHAR_W-1:0] eofm_char(logic [POS_W-1:0] p);
    logic [1:0] b;
    b = 2'(EOFM_LEN - p - 4'd1);
    if (p >= EOFM_LEN) begin
      return '0;
    end
    return EOFM_TEXT[{b, 3'b000} +: CHAR_W];
  endfunction

  function automatic logic is_vowel(logic [CHAR_W-1:0] c);
    return (c == "a") || (c == "i") || (c == "u") || (c == "e") ||
           (c == "o") || (c == "I") || (c == "E");
  endfunction

  // One step of the syllable DFA
  function automatic logic [SYL_W-1:0] syl_next(logic [SYL_W-1:0] s, logic [CHAR_W-1:0] c);
    logic bnd;
    logic [SYL_W-1:0] nx;
    bnd = (s == SYL_START) || (s == SYL_VOWEL) || (s == SYL_N);
    if (s >= SYL_DEAD) begin
      nx = SYL_DEAD;
    end else if (is_vowel(c)) begin
      nx = (s == SYL_C) ? SYL_DEAD : SYL_VOWEL;
    end else begin
      unique case (c)
        "t": nx = bnd ? SYL_T : SYL_DEAD;
        "s": nx = bnd ? SYL_S : ((s == SYL_T) ? SYL_GLIDE : SYL_DEAD);
        "c": nx = bnd ? SYL_C : SYL_DEAD;
        "h": begin
          if ((s == SYL_S) || (s == SYL_C)) nx = SYL_GLIDE;
          else nx = bnd ? SYL_ONSET : SYL_DEAD;
        end
        "n": begin
          if (s == SYL_VOWEL) nx = SYL_N;
          else if ((s == SYL_START) || (s == SYL_N)) nx = SYL_ONSET;
          else nx = SYL_DEAD;
        end
        "y": nx = (bnd || (s == SYL_ONSET)) ? SYL_GLIDE : SYL_DEAD;
        "d", "w", "z", "j": nx = bnd ? SYL_GLIDE : SYL_DEAD;
        "b", "g", "k", "m", "p", "r": nx = bnd ? SYL_ONSET : SYL_DEAD;
        default: nx = SYL_DEAD;
      endcase
    end
    return nx;
  endfunction

endpackage

// File: hdl/romaji_word_token_scanner_top.sv
// A word's token is valid in the cycle after its last character transfer.
// Throughput: one character per cycle unless an untaken token waits; each character
// steps every DFA and match flag; the result register frees when the consumer takes it.
// Reset (rst_ni low, asynchronous): word state returns to the start of a word,
// all match flags set, no token pending.
// Top level of the romaji word token scanner. Depends on rwts_pkg.
module romaji_word_token_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rwts_pkg::S_DATA_W-1:0] s_axis_tdata_i,  // [7:0] ch
  input  logic                          s_axis_tlast_i,  // end_of_word
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rwts_pkg::M_DATA_W-1:0] m_axis_tdata_o   // [3:0] token_kind, [7:4] zero
);
  import rwts_pkg::*;

  logic [SYL_W-1:0]   syl_q, syl_d, syl_nx;
  logic [PER_W-1:0]   per_q, per_d, per_nx;
  logic [MATCH_W-1:0] match_q, match_d, match_nx;
  logic [POS_W-1:0]   pos_q, pos_d, pos_nx;
  logic               cap_q, cap_d, cap_nx;
  logic               out_valid_q;
  tok_e               kind_q, kind;
  logic               s_fire;
  logic [CHAR_W-1:0]  ch;
  logic               syl_accept;

  assign ch     = s_axis_tdata_i[CHAR_W-1:0];
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Accept while the result register is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  // Step the match flags, the DFAs, the position counter and the last-letter flag
  always_comb begin
    match_nx = match_q;
    for (int unsigned i = 0; i < NUM_RESERVED; i++) begin
      if ((pos_q >= RW_LEN[i]) || (rw_char(i, pos_q) != ch)) begin
        match_nx[i] = 1'b0;
      end
    end
    if ((pos_q >= EOFM_LEN) || (eofm_char(pos_q) != ch)) begin
      match_nx[NUM_RESERVED] = 1'b0;
    end
    syl_nx = syl_next(syl_q, ch);
    per_nx = ((per_q == PER_START) && (ch == ".")) ? PER_ONE : PER_DEAD;
    cap_nx = (ch == "I") || (ch == "E");
    pos_nx = (pos_q == POS_MAX) ? pos_q : pos_q + 4'd1;
  end

  // Classify the word from its updated state
  always_comb begin
    syl_accept = (syl_nx == SYL_START) || (syl_nx == SYL_VOWEL) || (syl_nx == SYL_N);
    kind = TOK_ERROR;
    if (match_nx[NUM_RESERVED] && (pos_nx == EOFM_LEN)) begin
      kind = TOK_EOFM;
    end else if (syl_accept) begin
      kind = cap_nx ? TOK_WORD2 : TOK_WORD1;
      for (int unsigned i = 0; i < NUM_RESERVED; i++) begin
        if (match_nx[i] && (RW_LEN[i] == pos_nx)) begin
          kind = RW_CLASS[i];
        end
      end
    end else if (per_nx == PER_ONE) begin
      kind = TOK_PERIOD;
    end
  end

  // Advance word state on a transfer; restart after the last character
  always_comb begin
    syl_d   = syl_q;
    per_d   = per_q;
    match_d = match_q;
    pos_d   = pos_q;
    cap_d   = cap_q;
    if (s_fire) begin
      if (s_axis_tlast_i) begin
        syl_d   = SYL_START;
        per_d   = PER_START;
        match_d = '1;
        pos_d   = '0;
        cap_d   = 1'b0;
      end else begin
        syl_d   = syl_nx;
        per_d   = per_nx;
        match_d = match_nx;
        pos_d   = pos_nx;
        cap_d   = cap_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syl_q   <= SYL_START;
      per_q   <= PER_START;
      match_q <= '1;
      pos_q   <= '0;
      cap_q   <= 1'b0;
    end else begin
      syl_q   <= syl_d;
      per_q   <= per_d;
      match_q <= match_d;
      pos_q   <= pos_d;
      cap_q   <= cap_d;
    end
  end

  // Hold the token until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast_i) begin
      kind_q <= kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - 4){1'b0}}, kind_q};

`ifndef SYNTH
  // A word end restarts every DFA and the position counter
  a_word_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> (pos_q == '0) && (syl_q == SYL_START) &&
                                 (per_q == PER_START) && !cap_q)
    else $error("word state not restarted after last character");

  // At the start of a word every match flag is set
  a_match_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (match_q == '1))
    else $error("match flags not all set at word start");

  // The position counter saturates
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == POS_MAX) && s_fire && !s_axis_tlast_i |=> (pos_q == POS_MAX))
    else $error("position counter wrapped");

  // The dead syllable state is absorbing within a word
  a_syl_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (syl_q == SYL_DEAD) && s_fire && !s_axis_tlast_i |=> (syl_q == SYL_DEAD))
    else $error("syllable DFA left its dead state");

  // Every word end yields a pending token
  a_token_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("no token after last character");
`endif

endmodule
